// ----- hdl/ubse_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, widths and the standard rate table for the baud setting encoder
package ubse_pkg;

  localparam int RateW    = 32;
  localparam int MaxRateW = 24;
  localparam int ActualW  = 29;
  localparam int MantW    = 9;
  localparam int ExpW     = 3;
  localparam int StdIdxW  = 5;
  localparam int StdW     = 23;
  localparam int QuoW     = 29;
  localparam int StepW    = 5;

  localparam logic [QuoW-1:0]     ClockBase  = 29'd384000000;
  localparam logic [QuoW-1:0]     MantLimit  = 29'd512;
  localparam logic [MantW-1:0]    MantTrim   = 9'd511;
  localparam logic [ExpW-1:0]     ExpMax     = 3'd7;
  localparam logic [7:0]          DivMark    = 8'h80;
  localparam logic [StdIdxW-1:0]  StdCount   = 5'd25;
  localparam logic [StepW-1:0]    DivLast    = 5'(QuoW - 1);
  localparam logic [MaxRateW-1:0] MaxRateRst = 24'd12000000;

  function automatic logic [StdW-1:0] std_rate(input logic [StdIdxW-1:0] idx);
    logic [StdW-1:0] r;
    unique case (idx)
      5'd0:    r = 23'd75;
      5'd1:    r = 23'd150;
      5'd2:    r = 23'd300;
      5'd3:    r = 23'd600;
      5'd4:    r = 23'd1200;
      5'd5:    r = 23'd1800;
      5'd6:    r = 23'd2400;
      5'd7:    r = 23'd3600;
      5'd8:    r = 23'd4800;
      5'd9:    r = 23'd7200;
      5'd10:   r = 23'd9600;
      5'd11:   r = 23'd14400;
      5'd12:   r = 23'd19200;
      5'd13:   r = 23'd28800;
      5'd14:   r = 23'd38400;
      5'd15:   r = 23'd57600;
      5'd16:   r = 23'd115200;
      5'd17:   r = 23'd230400;
      5'd18:   r = 23'd460800;
      5'd19:   r = 23'd614400;
      5'd20:   r = 23'd921600;
      5'd21:   r = 23'd1228800;
      5'd22:   r = 23'd2457600;
      5'd23:   r = 23'd3000000;
      5'd24:   r = 23'd6000000;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ubse_div.sv -----
`timescale 1ns / 1ps
// restoring divider, fixed clock base dividend over a 32-bit divisor, one bit per cycle
module ubse_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ubse_pkg::RateW-1:0]    divisor,
  output logic                          done,
  output logic [ubse_pkg::QuoW-1:0]     quotient
);

  logic                          busy;
  logic [ubse_pkg::StepW-1:0]    cnt;
  logic [ubse_pkg::RateW-1:0]    rem;
  logic [ubse_pkg::QuoW-1:0]     quo;
  logic [ubse_pkg::RateW-1:0]    dvsr;
  logic [ubse_pkg::RateW:0]      trial;
  logic                          fits;

  assign trial    = {rem, quo[ubse_pkg::QuoW-1]};
  assign fits     = trial >= {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= ubse_pkg::DivLast;
      rem  <= '0;
      quo  <= ubse_pkg::ClockBase;
      dvsr <= divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (fits) begin
        rem <= ubse_pkg::RateW'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[ubse_pkg::RateW-1:0];
      end
      quo <= {quo[ubse_pkg::QuoW-2:0], fits};
    end
  end

endmodule

// ----- hdl/uart_baud_setting_encoder.sv -----
`timescale 1ns / 1ps
// top level: caps the request, scans the standard rates and builds the setting word
//
//  channel  | dir | handshake                 | payload
//  s_axis   | in  | s_axis_tvalid/tready      | tdata[31:0] requested_baud
//  m_axis   | out | m_axis_tvalid/tready      | tdata word+actual, tuser used_divisor
//  cfg      | in  | cfg_valid/cfg_ready       | cfg_data[23:0] max_rate
//
// direct form: when the capped rate is a standard rate, the result follows the first division
// divisor form: otherwise the first quotient is normalized and divided again; each division is
// 29 one-bit steps and then a done strobe, normalize shifts the mantissa right by two per step,
// trims it at the top exponent and then leaves; the table scan overlaps the first division
// rst is synchronous, clears the sequencer and loads max_rate with 12000000
// s_axis_tready is high only while idle; a result holds until m_axis_tready
module uart_baud_setting_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // requested_baud
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [63:0]                      m_axis_tdata,  // setting_word, actual_baud, 3'b0
  output logic                             m_axis_tuser,  // used_divisor
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ubse_pkg::MaxRateW-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                        state;
  logic [ubse_pkg::MaxRateW-1:0]     max_rate;
  logic [ubse_pkg::RateW-1:0]        rate;
  logic [ubse_pkg::RateW-1:0]        capped;
  logic [ubse_pkg::StdIdxW-1:0]      scan_idx;
  logic                              found;
  logic [ubse_pkg::QuoW-1:0]         mant;
  logic [ubse_pkg::ExpW-1:0]         expo;
  logic [31:0]                       word;
  logic [ubse_pkg::ActualW-1:0]      actual;
  logic                              used;
  logic                              div_start;
  logic                              div_done;
  logic [ubse_pkg::RateW-1:0]        div_divisor;
  logic [ubse_pkg::QuoW-1:0]         div_quo;
  logic                              in_fire;
  logic                              norm_end;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {3'b000, actual, word};
  assign m_axis_tuser  = used;

  assign capped = (max_rate != '0 && s_axis_tdata > {8'b0, max_rate})
                ? {8'b0, max_rate} : s_axis_tdata;

  assign norm_end = (state == ST_NORM) && (mant < ubse_pkg::MantLimit);

  assign div_start   = in_fire || norm_end;
  assign div_divisor = (state == ST_IDLE) ? capped : 32'(mant);

  ubse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate <= ubse_pkg::MaxRateRst;
    end else if (cfg_valid && cfg_ready) begin
      max_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            state <= found ? ST_OUT : ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm_end) begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rate     <= capped;
        scan_idx <= '0;
        found    <= 1'b0;
        expo     <= '0;
      end
      ST_DIV1: begin
        if (scan_idx != ubse_pkg::StdCount) begin
          scan_idx <= scan_idx + 1'b1;
          if (rate == 32'(ubse_pkg::std_rate(scan_idx))) begin
            found <= 1'b1;
          end
        end
        if (div_done) begin
          mant   <= (div_quo == '0) ? 29'd1 : div_quo;
          word   <= rate;
          actual <= rate[ubse_pkg::ActualW-1:0];
          used   <= 1'b0;
        end
      end
      ST_NORM: begin
        if (mant >= ubse_pkg::MantLimit) begin
          if (expo != ubse_pkg::ExpMax) begin
            mant <= {2'b00, mant[ubse_pkg::QuoW-1:2]};
            expo <= expo + 1'b1;
          end else begin
            mant <= 29'(ubse_pkg::MantTrim);
          end
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          word   <= {ubse_pkg::DivMark, 8'h00, 4'h0, expo, mant[8:0]};
          actual <= div_quo >> {expo, 1'b0};
          used   <= 1'b1;
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule
